### sv/trm_pkg.sv
// Package for the traffic rate meter: field widths, constants and the
// structs passed between the front and back modules. No dependencies.
package trm_pkg;

   localparam int unsigned CNT_W = 64;
   localparam int unsigned IFACE_W = 32;
   localparam int unsigned WIN_W = 15;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [CNT_W-1:0] MS_PER_SEC = 64'd1000;
   localparam logic [CNT_W-1:0] RATE_LIM = 64'd18446744073709551;
   localparam logic [CNT_W-1:0] SAVE_STEP_KIB = 64'd10240;
   localparam logic [WIN_W-1:0] WIN_RESET = 15'd30;
   localparam logic [WIN_W-1:0] IDLE_MAX = 15'h7FFF;

   localparam logic CSR_AUTO_MODE = 1'b0;
   localparam logic CSR_WINDOW_SAMPLES = 1'b1;

   // classified item from front to back
   typedef struct packed {
      logic             rebase;
      logic [CNT_W-1:0] din;
      logic [CNT_W-1:0] dout;
      logic [CNT_W-1:0] elapsed;
      logic             new_day;
      logic             sel_chg;
   } job_type;

   typedef struct packed {
      logic [CNT_W-1:0] in_rate;
      logic [CNT_W-1:0] out_rate;
      logic [CNT_W-1:0] today_up;
      logic [CNT_W-1:0] today_down;
      logic             save_request;
      logic             reselect_request;
   } result_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   // a * 1000 modulo 2^64 as 1024a - 16a - 8a
   function automatic logic [CNT_W-1:0] times_1000(input logic [CNT_W-1:0] a);
      return (a << 10) - (a << 4) - (a << 3);
   endfunction

endpackage

### sv/trm_front.sv
// Front end of the traffic rate meter: accepts samples, tracks the baseline
// and computes counter deltas and elapsed time. Uses trm_pkg.
module trm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        counters_valid,
   input  logic [trm_pkg::IFACE_W-1:0] iface_id,
   input  logic [trm_pkg::CNT_W-1:0]   in_count,
   input  logic [trm_pkg::CNT_W-1:0]   out_count,
   input  logic [trm_pkg::CNT_W-1:0]   now_ms,
   input  logic                        new_day,
   input  logic                        selection_changed,
   output logic                        job_valid,
   input  logic                        job_ready,
   output trm_pkg::job_type            job
);
   logic [trm_pkg::CNT_W-1:0] last_in_ff, last_out_ff, last_tick_ff;
   logic [trm_pkg::IFACE_W-1:0] base_iface_ff;
   logic base_ok_ff;
   logic [trm_pkg::CNT_W-1:0] last_in_in, last_out_in, last_tick_b;
   logic [trm_pkg::IFACE_W-1:0] base_iface_in;
   logic base_ok_in, base_ok_b;
   logic [trm_pkg::IFACE_W-1:0] base_iface_b;
   logic [trm_pkg::CNT_W-1:0] lin_b, lout_b, elapsed;
   logic good, rebase;

   assign in_ready = job_ready;
   assign job_valid = in_valid;

   always_comb begin
      lin_b = selection_changed ? '0 : last_in_ff;
      lout_b = selection_changed ? '0 : last_out_ff;
      last_tick_b = selection_changed ? '0 : last_tick_ff;
      base_ok_b = selection_changed ? 1'b0 : base_ok_ff;
      base_iface_b = selection_changed ? '0 : base_iface_ff;
      elapsed = (last_tick_b == '0) ? '0 : now_ms - last_tick_b;
      good = counters_valid && (iface_id != '0);
      rebase = !base_ok_b || selection_changed || (base_iface_b != iface_id) ||
               (in_count < lin_b) || (out_count < lout_b) || (elapsed == '0);
      job.rebase = !good || rebase;
      job.din = job.rebase ? '0 : in_count - lin_b;
      job.dout = job.rebase ? '0 : out_count - lout_b;
      job.elapsed = elapsed;
      job.new_day = new_day;
      job.sel_chg = selection_changed;
      last_in_in = good ? in_count : lin_b;
      last_out_in = good ? out_count : lout_b;
      base_iface_in = good ? iface_id : '0;
      base_ok_in = good;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_in_ff <= '0;
         last_out_ff <= '0;
         last_tick_ff <= '0;
         base_iface_ff <= '0;
         base_ok_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         last_in_ff <= last_in_in;
         last_out_ff <= last_out_in;
         last_tick_ff <= now_ms;
         base_iface_ff <= base_iface_in;
         base_ok_ff <= base_ok_in;
      end
   end
endmodule

### sv/trm_queue.sv
// Small FIFO between the front and back ends of the traffic rate meter.
// Uses trm_pkg.
module trm_queue #(
   parameter int unsigned DEPTH = trm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  trm_pkg::job_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output trm_pkg::job_type rd_data
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   trm_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic do_wr, do_rd;

   assign wr_ready = cnt_ff != (AW+1)'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (do_rd) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);
      end
   end
endmodule

### sv/trm_back.sv
// Back end of the traffic rate meter: serial rate division, daily totals,
// idle and save-window tracking, output register. Uses trm_pkg.
module trm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      auto_mode,
   input  logic [trm_pkg::WIN_W-1:0] window_samples,
   input  logic                      job_valid,
   output logic                      job_ready,
   input  trm_pkg::job_type          job,
   output logic                      res_valid,
   input  logic                      res_ready,
   output trm_pkg::result_type       res
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   localparam int unsigned W = trm_pkg::CNT_W;
   // 0:in quotient 1:in frac 2:out quotient 3:out frac
   state_type state_ff, state_in;
   trm_pkg::job_type job_ff;
   logic [1:0] phase_ff;
   logic [6:0] bit_ff;
   logic [W-1:0] quo_ff, rem_ff, num_ff;
   logic [W-1:0] q_ff, r_ff;
   logic [W-1:0] rate_in_ff, rate_out_ff;
   logic [trm_pkg::WIN_W-1:0] idle_ff, wphase_ff;
   logic [W-1:0] day_up_ff, day_down_ff, saved_kib_ff;
   logic day_seen_ff, saved_ok_ff;
   logic save_ff, reselect_ff;
   trm_pkg::result_type res_ff;
   logic res_valid_ff;

   logic [W:0] rem_sh;
   logic [W-1:0] rem_nx, quo_nx;
   logic qbit;
   logic [trm_pkg::WIN_W-1:0] win, idle0, idle_in, wphase_in;
   logic reselect;
   logic [W-1:0] up0, down0, up_in, down_in, kib, saved_in;
   logic seen0, ok0, seen_in, ok_in, save;

   assign job_ready = state_ff == ST_IDLE;
   assign res_valid = res_valid_ff;
   assign res = res_ff;

   always_comb begin
      rem_sh = {rem_ff, num_ff[W-1]};
      qbit = rem_sh >= {1'b0, job_ff.elapsed};
      rem_nx = qbit ? W'(rem_sh - {1'b0, job_ff.elapsed}) : rem_sh[W-1:0];
      quo_nx = {quo_ff[W-2:0], qbit};
   end

   always_comb begin
      win = (window_samples == '0) ? 15'd1 : window_samples;
      idle0 = job_ff.sel_chg ? '0 : idle_ff;
      idle_in = idle0;
      reselect = 1'b0;
      if (auto_mode) begin
         if (job_ff.din == '0 && job_ff.dout == '0) begin
            if (idle0 < trm_pkg::IDLE_MAX) idle_in = idle0 + 1'b1;
         end else idle_in = '0;
         if (idle_in >= win) begin
            reselect = 1'b1;
            idle_in = '0;
         end
      end
      up0 = job_ff.new_day ? '0 : day_up_ff;
      down0 = job_ff.new_day ? '0 : day_down_ff;
      seen0 = job_ff.new_day ? 1'b0 : day_seen_ff;
      ok0 = job_ff.new_day ? 1'b0 : saved_ok_ff;
      saved_in = job_ff.new_day ? '0 : saved_kib_ff;
      up_in = trm_pkg::sat_add(up0, job_ff.dout);
      down_in = trm_pkg::sat_add(down0, job_ff.din);
      kib = {10'd0, up_in[W-1:10]} + {10'd0, down_in[W-1:10]};
      seen_in = seen0;
      ok_in = ok0;
      save = 1'b0;
      wphase_in = wphase_ff + 1'b1;
      if (wphase_ff >= win - 1'b1) begin
         wphase_in = '0;
         if (!seen0) begin
            seen_in = 1'b1;
            saved_in = kib;
            ok_in = 1'b1;
         end else if (!ok0 || kib < saved_in) begin
            saved_in = kib;
            ok_in = 1'b1;
         end else if (kib - saved_in >= trm_pkg::SAVE_STEP_KIB) begin
            save = 1'b1;
            saved_in = kib;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (job_valid) state_in = job.rebase ? ST_FIN : ST_DIV;
         ST_DIV: if (bit_ff == 7'd0 && phase_ff == 2'd3) state_in = ST_FIN;
         ST_FIN: state_in = ST_OUT;
         ST_OUT: if (!res_valid_ff || res_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   function automatic logic [W-1:0] new_rate_f(input logic [W-1:0] fq);
      logic [W-1:0] base;
      base = trm_pkg::times_1000(q_ff);
      if (q_ff > trm_pkg::RATE_LIM) return '1;
      if (r_ff <= trm_pkg::RATE_LIM) return trm_pkg::sat_add(base, fq);
      return base;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idle_ff <= '0;
         wphase_ff <= '0;
         day_up_ff <= '0;
         day_down_ff <= '0;
         day_seen_ff <= 1'b0;
         saved_kib_ff <= '0;
         saved_ok_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && (!res_valid_ff || res_ready)) res_valid_ff <= 1'b1;
         else if (res_ready) res_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (job_valid) begin
               job_ff <= job;
               rate_in_ff <= '0;
               rate_out_ff <= '0;
               phase_ff <= 2'd0;
               bit_ff <= 7'(W - 1);
               num_ff <= job.din;
               rem_ff <= '0;
               quo_ff <= '0;
            end
            ST_DIV: begin
               if (bit_ff == 7'd0) begin
                  bit_ff <= 7'(W - 1);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  phase_ff <= phase_ff + 1'b1;
                  unique case (phase_ff)
                     2'd0, 2'd2: begin
                        q_ff <= quo_nx;
                        r_ff <= rem_nx;
                        num_ff <= trm_pkg::times_1000(rem_nx);
                     end
                     2'd1: begin
                        rate_in_ff <= new_rate_f(quo_nx);
                        num_ff <= job_ff.dout;
                     end
                     2'd3: rate_out_ff <= new_rate_f(quo_nx);
                     default: ;
                  endcase
               end else begin
                  rem_ff <= rem_nx;
                  num_ff <= {num_ff[W-2:0], 1'b0};
                  quo_ff <= quo_nx;
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            ST_FIN: begin
               idle_ff <= idle_in;
               wphase_ff <= wphase_in;
               day_up_ff <= up_in;
               day_down_ff <= down_in;
               day_seen_ff <= seen_in;
               saved_kib_ff <= saved_in;
               saved_ok_ff <= ok_in;
               save_ff <= save;
               reselect_ff <= reselect;
            end
            ST_OUT: if (!res_valid_ff || res_ready) begin
               res_ff.in_rate <= rate_in_ff;
               res_ff.out_rate <= rate_out_ff;
               res_ff.today_up <= day_up_ff;
               res_ff.today_down <= day_down_ff;
               res_ff.save_request <= save_ff;
               res_ff.reselect_request <= reselect_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

### sv/traffic_rate_meter_top.sv
// Traffic rate meter: samples counters, gives rates and daily totals.
// A sample with rates takes four 64-step divisions in the back end; a
// re-baseline sample skips them. The back end handles one sample at a
// time; the front end and a two-entry queue take new samples meanwhile.
// Synchronous active-high reset clears baseline, totals, phases and
// control registers to their defaults.
module traffic_rate_meter_top #(
   parameter int unsigned QUEUE_DEPTH = trm_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // counters_valid, iface_id, in_count, out_count, now_ms, new_day,
   // selection_changed; padded to 232 bits
   input  logic [231:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // in_rate, out_rate, today_up, today_down, save_request,
   // reselect_request; padded to 264 bits
   output logic [263:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [14:0]   csr_wdata
);
   logic auto_mode_ff;
   logic [trm_pkg::WIN_W-1:0] window_ff;
   trm_pkg::job_type fjob, qjob;
   logic f_valid, f_ready, q_valid, q_ready;
   trm_pkg::result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_mode_ff <= 1'b0;
         window_ff <= trm_pkg::WIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            trm_pkg::CSR_AUTO_MODE: auto_mode_ff <= csr_wdata[0];
            trm_pkg::CSR_WINDOW_SAMPLES: window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   trm_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .counters_valid(req_tdata[0]), .iface_id(req_tdata[32:1]),
      .in_count(req_tdata[96:33]), .out_count(req_tdata[160:97]),
      .now_ms(req_tdata[224:161]), .new_day(req_tdata[225]),
      .selection_changed(req_tdata[226]),
      .job_valid(f_valid), .job_ready(f_ready), .job(fjob)
   );

   trm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(fjob),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qjob)
   );

   trm_back u_back (
      .clock, .reset,
      .auto_mode(auto_mode_ff), .window_samples(window_ff),
      .job_valid(q_valid), .job_ready(q_ready), .job(qjob),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res)
   );

   assign rsp_tdata = {6'd0, res.reselect_request, res.save_request, res.today_down,
                       res.today_up, res.out_rate, res.in_rate};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready_q: assert property (@(posedge clock) disable iff (reset)
      req_tready == f_ready)
      else $error("front ready mismatch");
endmodule

### tb/tb_traffic_rate_meter_top.sv
// Testbench for traffic_rate_meter_top: drives counter-sample beats, predicts
// rates, daily totals, save and reselect flags, and checks each result beat.
// Depends on trm_pkg and the top module.
`timescale 1ns / 1ps

module tb_traffic_rate_meter_top;

   typedef struct {
      logic        valid;
      logic [31:0] iface;
      logic [63:0] cin;
      logic [63:0] cout;
      logic [63:0] now;
      logic        new_day;
      logic        sel_chg;
   } sample_type;

   typedef struct {
      logic [63:0] in_rate;
      logic [63:0] out_rate;
      logic [63:0] up;
      logic [63:0] down;
      logic        save;
      logic        reselect;
   } meter_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [231:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [263:0] rsp_tdata;
   logic csr_we = 0, csr_index = trm_pkg::CSR_AUTO_MODE;
   logic [14:0] csr_wdata = '0;

   traffic_rate_meter_top dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predictor state
   logic        m_auto;
   logic [14:0] m_win;
   logic [63:0] m_last_in, m_last_out, m_tick, m_up, m_down, m_saved;
   logic        m_base_ok, m_seen, m_saved_ok;
   logic [31:0] m_base_iface;
   logic [14:0] m_idle, m_phase;

   meter_type expected_q[$];
   int errors = 0;
   bit hold_off = 0;
   bit calm = 0;

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] bytes_per_sec(logic [63:0] d, logic [63:0] ms);
      logic [63:0] q, r, res, lim;
      lim = 64'hFFFF_FFFF_FFFF_FFFF / trm_pkg::MS_PER_SEC;
      if (ms == 0) return 0;
      q = d / ms;
      r = d % ms;
      if (q > lim) return '1;
      res = q * trm_pkg::MS_PER_SEC;
      if (r <= lim) res = sat_sum(res, r * trm_pkg::MS_PER_SEC / ms);
      return res;
   endfunction

   function automatic void meter_clear_baseline();
      m_last_in = 0; m_last_out = 0; m_base_iface = 0;
      m_base_ok = 0; m_tick = 0; m_idle = 0;
   endfunction

   task automatic meter_reset();
      m_auto = 0; m_win = 30;
      meter_clear_baseline();
      m_up = 0; m_down = 0; m_seen = 0; m_saved = 0; m_saved_ok = 0; m_phase = 0;
   endtask

   function automatic meter_type meter_step(sample_type s);
      meter_type r;
      logic [63:0] win, elapsed, din, dout, kib;
      bit rebase;
      din = 0; dout = 0;
      r = '{default: 0};
      win = (m_win == 0) ? 64'd1 : {49'd0, m_win};
      if (s.sel_chg) meter_clear_baseline();
      elapsed = (m_tick == 0) ? 64'd0 : s.now - m_tick;
      m_tick = s.now;
      if (!s.valid || s.iface == 0) begin
         m_base_ok = 0;
         m_base_iface = 0;
      end else begin
         rebase = !m_base_ok || s.sel_chg || m_base_iface != s.iface ||
                  s.cin < m_last_in || s.cout < m_last_out || elapsed == 0;
         if (!rebase) begin
            din = s.cin - m_last_in;
            dout = s.cout - m_last_out;
            r.in_rate = bytes_per_sec(din, elapsed);
            r.out_rate = bytes_per_sec(dout, elapsed);
         end
         m_last_in = s.cin; m_last_out = s.cout;
         m_base_iface = s.iface; m_base_ok = 1;
      end
      if (m_auto) begin
         if (din == 0 && dout == 0) begin
            if (m_idle != trm_pkg::IDLE_MAX) m_idle++;
         end else begin
            m_idle = 0;
         end
         if ({49'd0, m_idle} >= win) begin
            r.reselect = 1;
            m_idle = 0;
         end
      end
      if (s.new_day) begin
         m_up = 0; m_down = 0; m_seen = 0; m_saved = 0; m_saved_ok = 0;
      end
      m_up = sat_sum(m_up, dout);
      m_down = sat_sum(m_down, din);
      if ({49'd0, m_phase} >= win - 1) begin
         kib = m_up / 1024 + m_down / 1024;
         if (!m_seen) begin
            m_seen = 1; m_saved = kib; m_saved_ok = 1;
         end else if (!m_saved_ok || kib < m_saved) begin
            m_saved = kib; m_saved_ok = 1;
         end else if (kib - m_saved >= trm_pkg::SAVE_STEP_KIB) begin
            r.save = 1; m_saved = kib;
         end
         m_phase = 0;
      end else begin
         m_phase++;
      end
      r.up = m_up;
      r.down = m_down;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_sample(sample_type s, bit idle_ok);
      while (idle_ok && !calm && $urandom_range(99) < 28) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, s.sel_chg, s.new_day, s.now, s.cout, s.cin, s.iface, s.valid};
      do @(posedge clock); while (!req_tready);
      expected_q.insert(expected_q.size(), meter_step(s));
   endtask

   task automatic write_reg(logic idx, logic [14:0] v);
      req_tvalid <= 0;
      wait (expected_q.size() == 0);
      repeat (300) @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      if (idx == trm_pkg::CSR_AUTO_MODE) m_auto = v[0];
      else m_win = v;
   endtask

   // result checker
   always @(posedge clock) begin
      meter_type e;
      logic [63:0] a_in, a_out, a_up, a_down;
      if (!reset && rsp_tvalid && rsp_tready) begin
         {a_down, a_up, a_out, a_in} = rsp_tdata[255:0];
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (a_in !== e.in_rate) begin
               $error("in_rate exp %0d got %0d", e.in_rate, a_in); errors++;
            end
            if (a_out !== e.out_rate) begin
               $error("out_rate exp %0d got %0d", e.out_rate, a_out); errors++;
            end
            if (a_up !== e.up) begin
               $error("today_up exp %0d got %0d", e.up, a_up); errors++;
            end
            if (a_down !== e.down) begin
               $error("today_down exp %0d got %0d", e.down, a_down); errors++;
            end
            if (rsp_tdata[256] !== e.save) begin
               $error("save_request exp %0b got %0b", e.save, rsp_tdata[256]); errors++;
            end
            if (rsp_tdata[257] !== e.reselect) begin
               $error("reselect_request exp %0b got %0b", e.reselect, rsp_tdata[257]);
               errors++;
            end
         end
      end
   end

   // receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 0;
      else rsp_tready <= calm || ($urandom_range(99) >= 28);
   end

   // directed table: {valid, iface, in, out, now, new_day, sel_chg}
   sample_type dir_tab[] = '{
      '{1, 32'd1, 64'd0, 64'd0, 64'd1000, 0, 0},
      '{1, 32'd1, 64'd2000, 64'd1000, 64'd2000, 0, 0},
      '{1, 32'd1, 64'd2000, 64'd1000, 64'd2000, 0, 0},
      '{0, 32'd1, 64'd5000, 64'd5000, 64'd3000, 0, 0},
      '{1, 32'd0, 64'd5000, 64'd5000, 64'd4000, 0, 0},
      '{1, 32'd2, 64'd5000, 64'd5000, 64'd5000, 0, 0},
      '{1, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5001, 0, 0},
      '{1, 32'd2, 64'd10, 64'd10, 64'd6000, 0, 0},
      '{1, 32'd2, 64'd10000000, 64'd20000000, 64'd7000, 0, 0},
      '{1, 32'd2, 64'd20000000, 64'd40000000, 64'd8000, 0, 1},
      '{1, 32'd2, 64'd30000000, 64'd50000000, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0},
      '{1, 32'd2, 64'd40000000, 64'd60000000, 64'd999, 0, 0},
      '{1, 32'd2, 64'd40000001, 64'd60000000, 64'd0, 0, 0},
      '{1, 32'd2, 64'd50000000, 64'd60000000, 64'd7, 0, 0},
      '{1, 32'hFFFF_FFFF, 64'd0, 64'd0, 64'd8, 0, 0},
      '{1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd9, 0, 0},
      '{1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd10, 0, 0}
   };

   initial begin
      sample_type s;
      int base_id;
      logic [63:0] t, ci, co;
      meter_reset();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_tab[i]) send_sample(dir_tab[i], 1);
      write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'd0);
      write_reg(trm_pkg::CSR_AUTO_MODE, 1'b1);
      for (int i = 0; i < 6; i++) send_sample(dir_tab[i], 1);
      write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'h7FFF);
      for (int i = 0; i < 4; i++) send_sample(dir_tab[i], 1);
      write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'd3);
      t = 1; ci = 0; co = 0; base_id = 5;
      for (int n = 0; n < 1850; n++) begin
         if (n == 300) write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'd1);
         if (n == 700) write_reg(trm_pkg::CSR_AUTO_MODE, 1'b0);
         if (n == 900) write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'd30000);
         if (n == 1100) begin
            write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'd2);
            write_reg(trm_pkg::CSR_AUTO_MODE, 1'b1);
         end
         if (n == 1400) write_reg(trm_pkg::CSR_WINDOW_SAMPLES, 15'd5);
         calm = (n >= 500 && n < 650);
         if (n == 1000) fork
            begin
               hold_off = 1;
               repeat (2000) @(posedge clock);
               hold_off = 0;
            end
         join_none
         t += $urandom_range(2000);
         if ($urandom_range(3) == 0) begin
            ci += $urandom_range(100);
            co += $urandom_range(3) == 0 ? 0 : $urandom_range(100);
         end else if ($urandom_range(9) == 0) begin
            ci += rand64() >> $urandom_range(63);
            co += rand64() >> $urandom_range(63);
         end else begin
            ci += {$urandom_range(32'h00FF_FFFF), 4'd0};
            co += {$urandom_range(32'h00FF_FFFF), 4'd0};
         end
         s = '{1, base_id, ci, co, t, 0, 0};
         case ($urandom_range(39))
            0: s.valid = 0;
            1: s.iface = 0;
            2: s.iface = $urandom;
            3: s.sel_chg = 1;
            4: s.new_day = 1;
            5: s.now = rand64();
            6: begin s.cin = rand64(); s.cout = rand64(); end
            7: s.now = 0;
            default: ;
         endcase
         send_sample(s, 1);
      end
      req_tvalid <= 0;
      fork
         begin
            wait (expected_q.size() == 0);
            repeat (400) @(posedge clock);
         end
         begin
            repeat (3000000) @(posedge clock);
            $display("FAIL");
            $finish;
         end
      join_any
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #60ms;
      $display("FAIL");
      $finish;
   end

endmodule

### files.f
sv/trm_pkg.sv
sv/trm_front.sv
sv/trm_queue.sv
sv/trm_back.sv
sv/traffic_rate_meter_top.sv
tb/tb_traffic_rate_meter_top.sv
